// ===== hw/rtl/lidar_point_packet_parser_macros.svh =====
// Assertion macros for the lidar point packet parser.
// Used by the top level; no other dependencies.
`ifndef LIDAR_POINT_PACKET_PARSER_MACROS_SVH
`define LIDAR_POINT_PACKET_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LPP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define LPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define LPP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/lpp_pkg.sv =====
// Package for the lidar point packet parser: constants, CRC function,
// controller state type and command/status structs. No dependencies.
package lpp_pkg;

	localparam int POINTS_PER_FRAME_DEF = 12;
	localparam int PTS_START = 6;

	localparam logic [7:0] CRC_POLY   = 8'h4D;
	localparam logic [7:0] HEADER_RST = 8'd84;
	localparam logic [7:0] LENGTH_RST = 8'd44;

	localparam logic REG_HEADER = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		ST_RX,
		ST_RD,
		ST_LD
	} state_t;

	typedef struct packed {
		logic byte_en;
		logic rd_en;
		logic ld_pt;
		logic ld_err;
		logic emit_clr;
		logic emit_inc;
	} ctl_cmd_t;

	typedef struct packed {
		logic at_crc;
		logic crc_match;
		logic emit_last;
	} dp_stat_t;

	// MSB-first CRC-8, one byte
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/lpp_ctrl.sv =====
// Controller FSM of the lidar point packet parser.
// Uses lpp_pkg; drives datapath commands and the handshake flags.
module lpp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  lpp_pkg::dp_stat_t stat,
	output lpp_pkg::ctl_cmd_t cmd
);

	lpp_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic acc;
	logic out_free;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != lpp_pkg::ST_RX) || (out_valid_q && stat.at_crc);
	assign acc       = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpp_pkg::ST_RX;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_pt || cmd.ld_err) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			lpp_pkg::ST_RX: begin
				cmd.byte_en = acc;
				if (acc && stat.at_crc) begin
					if (stat.crc_match) begin
						cmd.emit_clr = 1'b1;
						state_d      = lpp_pkg::ST_RD;
					end else begin
						cmd.ld_err = 1'b1;
					end
				end
			end
			lpp_pkg::ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = lpp_pkg::ST_LD;
			end
			lpp_pkg::ST_LD: begin
				if (out_free) begin
					cmd.ld_pt = 1'b1;
					if (stat.emit_last) begin
						state_d = lpp_pkg::ST_RX;
					end else begin
						cmd.emit_inc = 1'b1;
						state_d      = lpp_pkg::ST_RD;
					end
				end
			end
			default: state_d = lpp_pkg::ST_RX;
		endcase
	end

endmodule

// ===== hw/rtl/lpp_datapath.sv =====
// Datapath of the lidar point packet parser: frame position, CRC, point
// memory, frame words and output registers. Uses lpp_pkg.
module lpp_datapath #(
	parameter int POINTS_PER_FRAME = lpp_pkg::POINTS_PER_FRAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic [7:0]        rx_byte,
	input  lpp_pkg::ctl_cmd_t cmd,
	output lpp_pkg::dp_stat_t stat,
	output logic              crc_ok,
	output logic [3:0]        point_index,
	output logic [15:0]       distance,
	output logic [7:0]        confidence,
	output logic [15:0]       rotation_speed,
	output logic [15:0]       first_angle,
	output logic [15:0]       final_angle,
	output logic [15:0]       frame_time,
	output logic              last
);

	localparam int PTS_END = lpp_pkg::PTS_START + 3 * POINTS_PER_FRAME;
	localparam int CRC_POS = PTS_END + 4;
	localparam int POS_W   = $clog2(CRC_POS + 1);
	localparam int PIDX_W  = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

	localparam logic [POS_W-1:0] P_SPD_LO = POS_W'(2);
	localparam logic [POS_W-1:0] P_SPD_HI = POS_W'(3);
	localparam logic [POS_W-1:0] P_ANG_LO = POS_W'(4);
	localparam logic [POS_W-1:0] P_ANG_HI = POS_W'(5);
	localparam logic [POS_W-1:0] P_PTS    = POS_W'(lpp_pkg::PTS_START);
	localparam logic [POS_W-1:0] P_END_LO = POS_W'(PTS_END);
	localparam logic [POS_W-1:0] P_END_HI = POS_W'(PTS_END + 1);
	localparam logic [POS_W-1:0] P_TS_LO  = POS_W'(PTS_END + 2);
	localparam logic [POS_W-1:0] P_TS_HI  = POS_W'(PTS_END + 3);
	localparam logic [POS_W-1:0] P_CRC    = POS_W'(CRC_POS);
	localparam logic [PIDX_W-1:0] IDX_LAST = PIDX_W'(POINTS_PER_FRAME - 1);

	logic [7:0]        hdr_q, len_q;
	logic [POS_W-1:0]  pos_q;
	logic [7:0]        crc_q;
	logic [1:0]        phase_q;
	logic [PIDX_W-1:0] pt_idx_q;
	logic [PIDX_W-1:0] emit_idx_q;
	logic [7:0]        pt_lo_q, pt_hi_q;
	logic [15:0]       speed_q, start_q, end_q, time_q;
	logic [23:0]       rd_data_q;
	logic [23:0]       pt_mem [POINTS_PER_FRAME];
	logic              in_pts, bad_sync, pt_wr;
	logic [PIDX_W+3:0] idx_ext;

	assign in_pts   = (pos_q >= P_PTS) && (pos_q < P_END_LO);
	assign bad_sync = ((pos_q == '0) && (rx_byte != hdr_q))
	               || ((pos_q == POS_W'(1)) && (rx_byte != len_q));
	assign pt_wr    = cmd.byte_en && in_pts && (phase_q == 2'd2);

	assign stat.at_crc    = (pos_q == P_CRC);
	assign stat.crc_match = (rx_byte == crc_q);
	assign stat.emit_last = (emit_idx_q == IDX_LAST);

	assign idx_ext = {4'b0, emit_idx_q};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= lpp_pkg::HEADER_RST;
			len_q <= lpp_pkg::LENGTH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lpp_pkg::REG_HEADER: hdr_q <= cfg_data;
				lpp_pkg::REG_LENGTH: len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame position, CRC, point byte phase, point index and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q      <= '0;
			phase_q    <= '0;
			pt_idx_q   <= '0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.byte_en) begin
				if (stat.at_crc || bad_sync) begin
					pos_q    <= '0;
					crc_q    <= '0;
					phase_q  <= '0;
					pt_idx_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					crc_q <= lpp_pkg::crc8_next(crc_q, rx_byte);
					if (in_pts) begin
						if (phase_q == 2'd2) begin
							phase_q  <= '0;
							pt_idx_q <= pt_idx_q + PIDX_W'(1);
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
			end
			if (cmd.emit_clr) begin
				emit_idx_q <= '0;
			end else if (cmd.emit_inc) begin
				emit_idx_q <= emit_idx_q + PIDX_W'(1);
			end
		end
	end

	// frame words
	always_ff @(posedge clk) begin
		if (cmd.byte_en && !stat.at_crc) begin
			priority if (pos_q == P_SPD_LO) begin
				speed_q <= {8'd0, rx_byte};
			end else if (pos_q == P_SPD_HI) begin
				speed_q[15:8] <= rx_byte;
			end else if (pos_q == P_ANG_LO) begin
				start_q <= {8'd0, rx_byte};
			end else if (pos_q == P_ANG_HI) begin
				start_q[15:8] <= rx_byte;
			end else if (in_pts) begin
				if (phase_q == 2'd0) begin
					pt_lo_q <= rx_byte;
				end else if (phase_q == 2'd1) begin
					pt_hi_q <= rx_byte;
				end
			end else if (pos_q == P_END_LO) begin
				end_q <= {8'd0, rx_byte};
			end else if (pos_q == P_END_HI) begin
				end_q[15:8] <= rx_byte;
			end else if (pos_q == P_TS_LO) begin
				time_q <= {8'd0, rx_byte};
			end else if (pos_q == P_TS_HI) begin
				time_q[15:8] <= rx_byte;
			end
		end
	end

	// point memory: confidence high, distance low
	always_ff @(posedge clk) begin
		if (pt_wr) begin
			pt_mem[pt_idx_q] <= {rx_byte, pt_hi_q, pt_lo_q};
		end
		if (cmd.rd_en) begin
			rd_data_q <= pt_mem[emit_idx_q];
		end
	end

	// output registers
	always_ff @(posedge clk) begin
		if (cmd.ld_pt) begin
			crc_ok         <= 1'b1;
			point_index    <= idx_ext[3:0];
			distance       <= rd_data_q[15:0];
			confidence     <= rd_data_q[23:16];
			rotation_speed <= speed_q;
			first_angle    <= start_q;
			final_angle    <= end_q;
			frame_time     <= time_q;
			last           <= stat.emit_last;
		end else if (cmd.ld_err) begin
			crc_ok         <= 1'b0;
			point_index    <= '0;
			distance       <= '0;
			confidence     <= '0;
			rotation_speed <= '0;
			first_angle    <= '0;
			final_angle    <= '0;
			frame_time     <= '0;
			last           <= 1'b1;
		end
	end

endmodule

// ===== hw/rtl/lidar_point_packet_parser.sv =====
// Lidar point packet parser, top level: controller plus datapath.
// Uses lpp_pkg, lpp_ctrl, lpp_datapath and the assertion macro header.
//
// Input channel: one received byte per transaction (in_valid/in_stall, rx_byte).
// Output channel: one point result per transaction (out_valid/out_stall).
// Config port: cfg_wr_en, cfg_index (0 header byte, 1 length byte), cfg_data.
// Ordinary frame bytes (taken one per cycle, not while emitting) give no result.
// A header or length mismatch drops back to the frame start.
// On the checksum byte of a good frame the block stalls its input and emits
// POINTS_PER_FRAME results, each from a point memory read (ST_RD) followed
// by an output load (ST_LD).
// A bad checksum gives one error result in the next cycle, without input stall.
// A checksum byte is held off while an earlier result is still waiting.
// When the receiver stalls, the current result holds and emission pauses.
// Reset: position and CRC clear, registers return to 84 and 44, no
// result pending; the point memory needs no clearing.
`include "lidar_point_packet_parser_macros.svh"

module lidar_point_packet_parser #(
	parameter int POINTS_PER_FRAME = lpp_pkg::POINTS_PER_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        crc_ok,
	output logic [3:0]  point_index,
	output logic [15:0] distance,
	output logic [7:0]  confidence,
	output logic [15:0] rotation_speed,
	output logic [15:0] first_angle,
	output logic [15:0] final_angle,
	output logic [15:0] frame_time,
	output logic        last
);

	localparam int PIDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

	lpp_pkg::ctl_cmd_t cmd;
	lpp_pkg::dp_stat_t stat;
	logic [PIDX_W+3:0] last_idx_ext;

	assign last_idx_ext = {4'b0, PIDX_W'(POINTS_PER_FRAME - 1)};

	lpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lpp_datapath #(
		.POINTS_PER_FRAME (POINTS_PER_FRAME)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.stat           (stat),
		.crc_ok         (crc_ok),
		.point_index    (point_index),
		.distance       (distance),
		.confidence     (confidence),
		.rotation_speed (rotation_speed),
		.first_angle    (first_angle),
		.final_angle    (final_angle),
		.frame_time     (frame_time),
		.last           (last)
	);

	`LPP_ASSERT_IMPL(a_err_is_last, clk, arst_n, out_valid && !crc_ok, last)
	`LPP_ASSERT_IMPL(a_last_idx, clk, arst_n, out_valid && crc_ok && last, point_index == last_idx_ext[3:0])
	`LPP_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.ld_pt || cmd.ld_err, !out_valid || !out_stall)
	`LPP_ASSERT_NEXT(a_busy_after_rd, clk, arst_n, cmd.rd_en, in_stall)

endmodule

// ===== bench/tb_lidar_point_packet_parser.sv =====
// Testbench for lidar_point_packet_parser: random and directed byte streams
// framed as scanner packets, checked against a built-in frame parser model.
// Depends on lpp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb_lidar_point_packet_parser;

	localparam int NPTS = lpp_pkg::POINTS_PER_FRAME_DEF;
	localparam int PT_FIRST = lpp_pkg::PTS_START;
	localparam int PT_END = PT_FIRST + 3 * NPTS;
	localparam int CRC_POS = PT_END + 4;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

	typedef struct packed {
		logic        crc_ok;
		logic [3:0]  idx;
		logic [15:0] dst;
		logic [7:0]  conf;
		logic [15:0] speed;
		logic [15:0] ang0;
		logic [15:0] ang1;
		logic [15:0] tstamp;
		logic        last;
	} point_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        crc_ok;
	logic [3:0]  point_index;
	logic [15:0] distance;
	logic [7:0]  confidence;
	logic [15:0] rotation_speed;
	logic [15:0] first_angle;
	logic [15:0] final_angle;
	logic [15:0] frame_time;
	logic        last;

	// parser model state
	logic [7:0]  header_value = lpp_pkg::HEADER_RST;
	logic [7:0]  length_value = lpp_pkg::LENGTH_RST;
	logic [5:0]  frame_pos = '0;
	logic [7:0]  frame_crc = '0;
	logic [23:0] point_mem [0:NPTS-1];
	logic [15:0] speed_w = '0;
	logic [15:0] ang0_w = '0;
	logic [15:0] ang1_w = '0;
	logic [15:0] tstamp_w = '0;

	logic [7:0]    rx_pending[$];
	point_result_t points_expected[$];

	int  send_idle_pct = 0;
	int  stall_pct = 0;
	int  hold_req = 0;
	int  hold_done = 0;
	int  mismatches = 0;
	bit  byte_taken = 0;

	lidar_point_packet_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.crc_ok(crc_ok),
		.point_index(point_index),
		.distance(distance),
		.confidence(confidence),
		.rotation_speed(rotation_speed),
		.first_angle(first_angle),
		.final_angle(final_angle),
		.frame_time(frame_time),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		r = c ^ b;
		repeat (8) r = r[7] ? ((r << 1) ^ lpp_pkg::CRC_POLY) : (r << 1);
		return r;
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b);
		point_result_t r;
		int rel;
		bit keep;
		keep = 1;
		if (frame_pos == CRC_POS) begin
			if (b == frame_crc) begin
				for (int k = 0; k < NPTS; k++) begin
					r.crc_ok = 1'b1;
					r.idx = k[3:0];
					r.dst = point_mem[k][15:0];
					r.conf = point_mem[k][23:16];
					r.speed = speed_w;
					r.ang0 = ang0_w;
					r.ang1 = ang1_w;
					r.tstamp = tstamp_w;
					r.last = (k == NPTS - 1);
					points_expected.push_back(r);
				end
			end else begin
				r = '0;
				r.last = 1'b1;
				points_expected.push_back(r);
				for (int k = 0; k < NPTS; k++) point_mem[k] = '0;
				speed_w = '0;
				ang0_w = '0;
				ang1_w = '0;
				tstamp_w = '0;
			end
			frame_pos = '0;
			frame_crc = '0;
		end else begin
			case (frame_pos)
				0: keep = (b == header_value);
				1: keep = (b == length_value);
				2: speed_w[7:0] = b;
				3: speed_w[15:8] = b;
				4: ang0_w[7:0] = b;
				5: ang0_w[15:8] = b;
				PT_END: ang1_w[7:0] = b;
				PT_END + 1: ang1_w[15:8] = b;
				PT_END + 2: tstamp_w[7:0] = b;
				PT_END + 3: tstamp_w[15:8] = b;
				default: begin
					rel = frame_pos - PT_FIRST;
					point_mem[rel / 3][(rel % 3) * 8 +: 8] = b;
				end
			endcase
			if (keep) begin
				frame_crc = crc8_step(frame_crc, b);
				frame_pos = frame_pos + 1'b1;
			end else begin
				frame_pos = '0;
				frame_crc = '0;
			end
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || byte_taken)) begin
			if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte <= rx_pending.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off once hold_req is raised
	always @(negedge clk) begin
		if (hold_done < hold_req) begin
			out_stall <= 1'b1;
			hold_done <= hold_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: check results first, then feed accepted bytes to the model
	always @(posedge clk) begin
		point_result_t got, want;
		byte_taken = arst_n && in_valid === 1'b1 && in_stall === 1'b0;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = {crc_ok, point_index, distance, confidence, rotation_speed,
				first_angle, final_angle, frame_time, last};
			if (points_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result transaction %h", $realtime, got);
			end else begin
				want = points_expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: exp ok=%0d idx=%0d dist=%h conf=%h spd=%h a0=%h a1=%h ts=%h last=%0d",
							$realtime, want.crc_ok, want.idx, want.dst, want.conf, want.speed,
							want.ang0, want.ang1, want.tstamp, want.last);
						$display("%0t: got ok=%0d idx=%0d dist=%h conf=%h spd=%h a0=%h a1=%h ts=%h last=%0d",
							$realtime, got.crc_ok, got.idx, got.dst, got.conf, got.speed,
							got.ang0, got.ang1, got.tstamp, got.last);
					end
				end
			end
		end
		if (byte_taken)
			parse_rx_byte(rx_byte);
	end

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == lpp_pkg::REG_HEADER)
			header_value = val;
		else
			length_value = val;
	endtask

	// keep < CRC_POS + 1 leaves a truncated frame in the stream
	task automatic queue_frame(input fill_t fill, input bit corrupt, input int keep);
		logic [7:0] fb [0:CRC_POS];
		logic [7:0] c;
		fb[0] = header_value;
		fb[1] = length_value;
		for (int i = 2; i < CRC_POS; i++) begin
			case (fill)
				FILL_ZERO: fb[i] = 8'h00;
				FILL_ONES: fb[i] = 8'hFF;
				default:   fb[i] = $urandom_range(255);
			endcase
		end
		c = '0;
		for (int i = 0; i < CRC_POS; i++) c = crc8_step(c, fb[i]);
		fb[CRC_POS] = corrupt ? (c ^ 8'($urandom_range(1, 255))) : c;
		for (int i = 0; i < keep; i++) rx_pending.push_back(fb[i]);
	endtask

	task automatic drain();
		while (rx_pending.size() != 0 || in_valid || points_expected.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int waited;
		for (int k = 0; k < NPTS; k++) point_mem[k] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no idling: all-ones payload, then header and length mismatches
		send_idle_pct = 0;
		stall_pct = 0;
		queue_frame(FILL_ONES, 0, CRC_POS + 1);
		rx_pending.push_back(~header_value);
		rx_pending.push_back(header_value);
		rx_pending.push_back(~length_value);
		drain();

		// sender idle, extreme register values, checksum error
		write_reg(lpp_pkg::REG_HEADER, 8'h00);
		write_reg(lpp_pkg::REG_LENGTH, 8'hFF);
		send_idle_pct = 67;
		stall_pct = 0;
		queue_frame(FILL_RANDOM, 1, CRC_POS + 1);
		drain();

		// receiver stalling, long hold-off while the sender keeps offering bytes
		write_reg(lpp_pkg::REG_HEADER, 8'($urandom_range(255)));
		write_reg(lpp_pkg::REG_LENGTH, 8'($urandom_range(255)));
		send_idle_pct = 0;
		stall_pct = 67;
		hold_req = 300;
		queue_frame(FILL_RANDOM, 0, CRC_POS + 1);
		repeat (6) rx_pending.push_back(8'($urandom_range(255)));
		drain();

		// both sides idle a little, reset values back, truncated frame
		write_reg(lpp_pkg::REG_HEADER, lpp_pkg::HEADER_RST);
		write_reg(lpp_pkg::REG_LENGTH, lpp_pkg::LENGTH_RST);
		send_idle_pct = 7;
		stall_pct = 7;
		queue_frame(FILL_RANDOM, 0, 12);

		waited = 0;
		while ((rx_pending.size() != 0 || in_valid || points_expected.size() != 0)
				&& waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
		if (mismatches == 0 && points_expected.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
